### sv/ette_pkg.sv
package ette_pkg;

  localparam int unsigned TOGGLE_COUNT = 32;
  localparam int unsigned TOG_W        = $clog2(TOGGLE_COUNT + 1);
  localparam int unsigned LAST_IDX     = TOGGLE_COUNT - 1;
  localparam int unsigned REST_MAX     = TOGGLE_COUNT - 3;

  // operation codes
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_CALIB   = 2'd1;
  localparam logic [1:0] OP_MEAS    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIN_LEN  = 2'd0;
  localparam logic [1:0] CFG_PERCENT  = 2'd1;
  localparam logic [1:0] CFG_MIN_REST = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  WIN_LEN_RST  = 8'd55;
  localparam logic [6:0]  PERCENT_RST  = 7'd20;
  localparam logic [15:0] MIN_REST_RST = 16'd20;

  // x / 100 for 17-bit x: reciprocal estimate is exact or one too high
  localparam int unsigned DIV100_MUL = 1311;

  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  sample;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic        note_on;
    logic [31:0] toggle_time_ms;
    logic [7:0]  toggle_index;
    logic        last;
    logic [30:0] tempo_ms;
    logic        tempo_valid;
  } out_t;

  typedef struct packed {
    logic clear_all;
    logic peak_upd;
    logic win_add;
    logic thr_ld;
    logic win_end;
    logic set_ref;
    logic start_pend;
    logic clr_pend;
    logic span_ld;
    logic rest_upd;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       finished;
    logic       win_done;
    logic       ref_set;
    logic       cur_state;
    logic       pending;
    logic       present;
    logic       is_last;
    logic       div_done;
    logic       out_free;
  } sts_t;

  function automatic logic [10:0] div100(input logic [16:0] x);
    logic [27:0] p;
    logic [10:0] q;
    logic [17:0] back;
    p    = 28'(x) * 28'(DIV100_MUL);
    q    = p[27:17];
    back = 18'(q) * 18'd100;
    if (back > 18'(x)) begin
      q = q - 11'd1;
    end
    return q;
  endfunction

endpackage

### sv/envelope_toggle_tempo_estimator.sv
// Envelope toggle tempo estimator.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per sample,
// carrying the operation (restart, calibration sample, measurement sample),
// the converter reading and its millisecond time stamp. Output channel
// (out_valid_o / out_stall_i / out_data_o): one beat per recorded toggle;
// the final toggle carries last and the averaged rest tempo.
// Restart, calibration and measurement samples that do not close a window
// leave the controller idle, and the next sample is taken in the following
// cycle. A sample that closes a window keeps the input stalled through the
// threshold divide, then the multiply and compare. A confirmed toggle then
// passes the rest span, rest sum and output load steps before its beat
// shows, the output load waiting for a free output register. The final
// toggle also runs the 32-step shift-subtract divider for the tempo.
// The output register holds a beat while out_stall_i is high; the next sample
// is still taken, and only a new toggle waits for the register to empty.
// Reset (rst_ni, asynchronous) clears control and toggle state and loads the
// defaults: window length 55, threshold 20 percent, minimum rest 20 ms.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
module envelope_toggle_tempo_estimator import ette_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  ette_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ette_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/ette_div.sv
module ette_div import ette_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [7:0]       divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [7:0]           rem_q, rem_d;
  logic [7:0]           dsr_q, dsr_d;
  logic [8:0]           rem_sh;
  logic                 fits;

  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};
  assign done_o = busy_q && (cnt_q == DIV_CNT_W'(DIV_W - 1));
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? 8'(rem_sh - {1'b0, dsr_q}) : rem_sh[7:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

### sv/ette_dp.sv
module ette_dp import ette_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_t                   in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  logic [7:0]       wlen_q;
  logic [6:0]       pct_q;
  logic [15:0]      minr_q;
  logic [9:0]       peak_q;
  logic [17:0]      sum_q;
  logic [7:0]       cnt_q;
  logic             ref_q, cur_q, pend_q, fin_q, present_q;
  logic [31:0]      ptime_q, prev_q, t_q, span_q, rsum_q;
  logic [7:0]       rcnt_q;
  logic [TOG_W-1:0] k_q;
  logic [16:0]      prod_q;
  logic [10:0]      thr_q;
  logic             out_valid_q;
  out_t             out_q, out_d;

  logic [7:0]       len;
  logic [18:0]      lim;
  logic             rest_ok;
  logic [32:0]      rsum_add;
  logic             tempo_ok;
  logic             div_done;
  logic [DIV_W-1:0] quo;

  assign len      = (wlen_q == 8'd0) ? 8'd1 : wlen_q;
  assign lim      = 19'(len) * 19'(thr_q);
  assign rest_ok  = present_q && (k_q >= TOG_W'(1)) && (k_q <= TOG_W'(REST_MAX))
                    && (span_q > 32'(minr_q));
  assign rsum_add = {1'b0, rsum_q} + {1'b0, span_q};
  assign tempo_ok = sts_o.is_last && (rcnt_q != 8'd0);

  assign sts_o.op        = in_data_i.operation;
  assign sts_o.finished  = fin_q;
  assign sts_o.win_done  = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len};
  assign sts_o.ref_set   = ref_q;
  assign sts_o.cur_state = cur_q;
  assign sts_o.pending   = pend_q;
  assign sts_o.present   = 19'(sum_q) > lim;
  assign sts_o.is_last   = k_q >= TOG_W'(LAST_IDX);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  ette_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rsum_q),
    .divisor_i  (rcnt_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    out_d.note_on        = present_q;
    out_d.toggle_time_ms = ptime_q;
    out_d.toggle_index   = 8'(k_q);
    out_d.last           = sts_o.is_last;
    out_d.tempo_ms       = '0;
    out_d.tempo_valid    = tempo_ok;
    if (tempo_ok) begin
      out_d.tempo_ms = quo[DIV_W-1] ? 31'h7FFF_FFFF : quo[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WIN_LEN_RST;
      pct_q       <= PERCENT_RST;
      minr_q      <= MIN_REST_RST;
      peak_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      ref_q       <= 1'b0;
      cur_q       <= 1'b0;
      pend_q      <= 1'b0;
      ptime_q     <= '0;
      k_q         <= '0;
      prev_q      <= '0;
      rsum_q      <= '0;
      rcnt_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIN_LEN:  wlen_q <= cfg_data_i[7:0];
          CFG_PERCENT:  pct_q  <= cfg_data_i[6:0];
          CFG_MIN_REST: minr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear_all) begin
        peak_q  <= '0;
        sum_q   <= '0;
        cnt_q   <= '0;
        ref_q   <= 1'b0;
        cur_q   <= 1'b0;
        pend_q  <= 1'b0;
        ptime_q <= '0;
        k_q     <= '0;
        prev_q  <= '0;
        rsum_q  <= '0;
        rcnt_q  <= '0;
        fin_q   <= 1'b0;
      end
      if (cmd_i.peak_upd && (in_data_i.sample > peak_q)) begin
        peak_q <= in_data_i.sample;
      end
      if (cmd_i.win_add) begin
        sum_q <= sum_q + 18'(in_data_i.sample);
        cnt_q <= cnt_q + 8'd1;
      end
      if (cmd_i.win_end) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.set_ref) begin
        ref_q <= 1'b1;
        cur_q <= sts_o.present;
      end
      if (cmd_i.start_pend) begin
        pend_q  <= 1'b1;
        ptime_q <= t_q;
      end
      if (cmd_i.clr_pend) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.rest_upd && rest_ok) begin
        rsum_q <= rsum_add[32] ? 32'hFFFF_FFFF : rsum_add[31:0];
        rcnt_q <= rcnt_q + 8'd1;
      end
      if (cmd_i.emit) begin
        prev_q <= ptime_q;
        cur_q  <= present_q;
        pend_q <= 1'b0;
        k_q    <= k_q + TOG_W'(1);
        if (sts_o.is_last) begin
          fin_q <= 1'b1;
        end
      end
      // hold the beat until taken
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_add) begin
      t_q    <= in_data_i.time_ms;
      prod_q <= 17'(peak_q) * 17'(pct_q);
    end
    if (cmd_i.thr_ld) begin
      thr_q <= div100(prod_q);
    end
    if (cmd_i.win_end) begin
      present_q <= sts_o.present;
    end
    if (cmd_i.span_ld) begin
      span_q <= ptime_q - prev_q;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/ette_ctrl.sv
module ette_ctrl import ette_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_THR   = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_SPAN  = 8'b0000_1000,
    S_REST  = 8'b0001_0000,
    S_DIVGO = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (sts_i.op)
            OP_RESTART: cmd_o.clear_all = 1'b1;
            OP_CALIB:   cmd_o.peak_upd  = 1'b1;
            OP_MEAS: begin
              if (!sts_i.finished) begin
                cmd_o.win_add = 1'b1;
                if (sts_i.win_done) begin
                  state_d = S_THR;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_THR: begin
        cmd_o.thr_ld = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.win_end = 1'b1;
        state_d       = S_IDLE;
        if (!sts_i.ref_set) begin
          cmd_o.set_ref = 1'b1;
        end else if (sts_i.present != sts_i.cur_state) begin
          if (!sts_i.pending) begin
            cmd_o.start_pend = 1'b1;
          end else begin
            state_d = S_SPAN;
          end
        end else begin
          cmd_o.clr_pend = 1'b1;
        end
      end
      S_SPAN: begin
        cmd_o.span_ld = 1'b1;
        state_d       = S_REST;
      end
      S_REST: begin
        cmd_o.rest_upd = 1'b1;
        state_d        = sts_i.is_last ? S_DIVGO : S_EMIT;
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
